/* hw/rtl/bhed_pkg.sv */
// Shared constants, codes and types for the brace hex escape decoder.
// No dependencies; compiled before every other file of the block.
package bhed_pkg;

    // Character and field widths
    localparam int CHAR_W  = 8;
    localparam int CNT_OUT_W = 16;
    localparam int LIMIT_W = 16;
    // Width of the internal decoded-character counter (range 4..32)
    localparam int CNT_W   = 16;

    // APB side
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'hFFFF;

    // Register indexes (word address)
    localparam logic REG_OUTPUT_LIMIT = 1'b0;

    // Characters of the escape syntax
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_D0    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_D9    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;

    // Result status codes
    typedef enum logic [1:0] {
        ST_BYTE  = 2'd0,
        ST_ERROR = 2'd1,
        ST_SKIP_END = 2'd2
    } t_status;

    // One result of the parser
    typedef struct packed {
        logic                 valid;
        logic [CHAR_W-1:0]    decoded_byte;
        t_status              status;
        logic [CNT_OUT_W-1:0] decoded_count;
        logic                 end_of_message;
    } t_result;

endpackage

/* hw/rtl/bhed_if.sv */
// Valid/ready channel interfaces for the character input and the result output.
// Depends on bhed_pkg for field widths.
interface bhed_char_if;
    logic                          valid;
    logic                          ready;
    logic [bhed_pkg::CHAR_W-1:0]   in_char;
    logic                          last_char;

    modport source (output valid, output in_char, output last_char, input ready);
    modport sink   (input valid, input in_char, input last_char, output ready);
endinterface

interface bhed_res_if;
    logic                            valid;
    logic                            ready;
    logic [bhed_pkg::CHAR_W-1:0]     decoded_byte;
    logic [1:0]                      status;
    logic [bhed_pkg::CNT_OUT_W-1:0]  decoded_count;
    logic                            end_of_message;

    modport source (output valid, output decoded_byte, output status,
                    output decoded_count, output end_of_message, input ready);
    modport sink   (input valid, input decoded_byte, input status,
                    input decoded_count, input end_of_message, output ready);
endinterface

/* hw/rtl/bhed_parse.sv */
// Escape parser: phase state machine, hex digit assembly and decoded-character count.
// Depends on bhed_pkg.
module bhed_parse (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [bhed_pkg::CHAR_W-1:0]     i_in_char,
    input  logic                            i_last_char,
    input  logic [bhed_pkg::LIMIT_W-1:0]    i_limit,
    output bhed_pkg::t_result               o_res
);
    import bhed_pkg::*;

    typedef enum logic [2:0] {
        PH_TEXT,
        PH_OPEN,
        PH_HEX1,
        PH_HEX2,
        PH_SKIP
    } t_phase;

    localparam logic [31:0] CNT_MAX = 32'((64'd1 << CNT_W) - 64'd1);

    t_phase            r_phase, n_phase;
    logic [3:0]        r_partial, n_partial;
    logic [7:0]        r_pending, n_pending;
    logic [CNT_W-1:0]  r_count, n_count;

    logic [31:0]       eff_limit;
    logic              at_limit;
    logic              is_digit, is_upper, is_hex;
    logic [3:0]        hex_val;
    t_phase            cur_phase;
    logic              res_byte, res_err, res_end;
    logic [CHAR_W-1:0] byte_val;

    // Limit clipped to what the counter can hold
    always_comb begin
        eff_limit = (32'(i_limit) > CNT_MAX) ? CNT_MAX : 32'(i_limit);
        at_limit  = (32'(r_count) >= eff_limit);
    end

    // Upper-case hex digit decode
    always_comb begin
        is_digit = (i_in_char >= CH_D0) && (i_in_char <= CH_D9);
        is_upper = (i_in_char >= CH_UA) && (i_in_char <= CH_UF);
        is_hex   = is_digit || is_upper;
        if (is_upper) begin
            hex_val = 4'(i_in_char - CH_UA + 8'd10);
        end else begin
            hex_val = 4'(i_in_char - CH_D0);
        end
    end

    // Next state and result for the item in hand
    always_comb begin
        cur_phase = (r_phase != PH_SKIP && at_limit) ? PH_SKIP : r_phase;
        n_phase   = cur_phase;
        n_partial = r_partial;
        n_pending = r_pending;
        n_count   = r_count;
        res_byte  = 1'b0;
        res_err   = 1'b0;
        res_end   = 1'b0;
        byte_val  = '0;

        case (cur_phase)
            PH_TEXT: begin
                if (i_in_char == CH_OPEN) begin
                    n_phase = PH_OPEN;
                end else begin
                    res_byte = 1'b1;
                    byte_val = i_in_char;
                end
            end
            PH_OPEN: begin
                if (i_in_char == CH_OPEN) begin
                    res_byte = 1'b1;
                    byte_val = CH_OPEN;
                    n_phase  = PH_TEXT;
                end else if (is_hex) begin
                    n_partial = hex_val;
                    n_phase   = PH_HEX1;
                end else begin
                    res_err = 1'b1;
                end
            end
            PH_HEX1: begin
                if (is_hex) begin
                    n_pending = {r_partial, hex_val};
                    n_phase   = PH_HEX2;
                end else begin
                    res_err = 1'b1;
                end
            end
            PH_HEX2: begin
                if (i_in_char == CH_CLOSE) begin
                    res_byte = 1'b1;
                    byte_val = r_pending;
                    n_phase  = PH_TEXT;
                end else begin
                    res_err = 1'b1;
                end
            end
            default: begin
                n_phase = PH_SKIP;
                res_end = i_last_char;
            end
        endcase

        if (res_err) begin
            n_phase = PH_SKIP;
        end else if (res_byte) begin
            n_count = r_count + 1'b1;
        end else if (!res_end && i_last_char && n_phase != PH_TEXT) begin
            // message ends inside an escape
            res_err = 1'b1;
        end

        o_res.valid          = res_byte || res_err || res_end;
        o_res.decoded_byte   = byte_val;
        o_res.status         = res_byte ? ST_BYTE : (res_err ? ST_ERROR : ST_SKIP_END);
        o_res.decoded_count  = CNT_OUT_W'(n_count);
        o_res.end_of_message = i_last_char;

        // back to a clean message after its last character
        if (i_last_char && o_res.valid) begin
            n_phase   = PH_TEXT;
            n_partial = '0;
            n_pending = '0;
            n_count   = '0;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TEXT;
            r_partial <= '0;
            r_pending <= '0;
            r_count   <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_partial <= n_partial;
            r_pending <= n_pending;
            r_count   <= n_count;
        end
    end

endmodule

/* hw/rtl/brace_hex_escape_decoder.sv */
// Brace hex escape decoder: one character per cycle in while the result output is not stalled, zero or one result out.
// An input transfer reaches result valid through the input register, the parser and the result register.
// A new character is taken while the last one moves on, as long as the result output is not stalled.
// Reset (synchronous, active low): parser back to normal text, count zero,
// output_limit back to 65535, both pipeline registers empty.
// Depends on bhed_pkg, bhed_if (bhed_char_if, bhed_res_if) and bhed_parse.
module brace_hex_escape_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bhed_char_if.sink                       i_in,
    bhed_res_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bhed_pkg::APB_AW-1:0]     paddr,
    input  logic [bhed_pkg::APB_DW-1:0]     pwdata,
    output logic [bhed_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import bhed_pkg::*;

    logic [LIMIT_W-1:0]  r_limit;
    logic                r_in_vld;
    logic [CHAR_W-1:0]   r_in_char;
    logic                r_in_last;
    logic                r_out_vld;
    t_result             r_out;
    t_result             parse_res;
    logic                out_free;
    logic                step;
    logic                cfg_wr;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RST;
        end else if (cfg_wr && paddr[APB_AW-1] == REG_OUTPUT_LIMIT) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_AW-1] == REG_OUTPUT_LIMIT) begin
            prdata = APB_DW'(r_limit);
        end
    end

    // Pipeline flow control
    assign out_free   = !r_out_vld || o_out.ready;
    assign step       = r_in_vld && out_free;
    assign i_in.ready = !r_in_vld || out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_char <= i_in.in_char;
            r_in_last <= i_in.last_char;
        end
    end

    bhed_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_in_char   (r_in_char),
        .i_last_char (r_in_last),
        .i_limit     (r_limit),
        .o_res       (parse_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step && parse_res.valid) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && parse_res.valid) begin
            r_out <= parse_res;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.decoded_byte   = r_out.decoded_byte;
    assign o_out.status         = r_out.status;
    assign o_out.decoded_count  = r_out.decoded_count;
    assign o_out.end_of_message = r_out.end_of_message;

endmodule
